// ===== src/lzss_decompressor_assert.svh =====
// Assertion macros for the LZSS decompressor.
// Included by the top level; depends on nothing else.
`ifndef LZSS_DECOMPRESSOR_ASSERT_SVH
`define LZSS_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LZSS_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZSS_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lzss_pkg.sv =====
// Shared types and constants for the LZSS decompressor.
// No dependencies.
package lzss_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int OFFSET_W     = $clog2(WINDOW_DEPTH);

  localparam logic [OFFSET_W-1:0] INIT_POS_RESET = 12'hFEE;

  // Channel payloads
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // What the parser makes of the current byte
  typedef enum logic [1:0] {
    TOK_FLAG   = 2'd0,
    TOK_LIT    = 2'd1,
    TOK_MATCH1 = 2'd2,
    TOK_MATCH2 = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t             kind;
    logic [OFFSET_W-1:0]   offset;
    logic [3:0]            len_m3;
  } tok_dec_t;

endpackage

// ===== src/lzss_decompressor.sv =====
// Top level of the LZSS decompressor: sequencer, shared pointer incrementer,
// output register. Depends on lzss_pkg, lzss_parser, lzss_window and the
// assertion header.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------
//  input    | in_valid / in_ready       | in_data  (in_item_t)
//  output   | out_valid / out_ready     | out_data (out_item_t)
//  config   | cfg_wr_en                 | cfg_wr_data (12 bit)
//
// A flag byte or first match byte is taken in IDLE alone; a literal goes to
// EMIT; each match byte is a window read (READ) then a window write (EMIT) on
// the single-port-per-direction RAM. A stalled output holds the sequencer.
// After reset and after every item marked last, a clearing pass writes zero
// to all WINDOW_DEPTH entries, one per cycle; in_ready is low
// meanwhile. Configuration writes are taken at any time and set the start
// position used after the next item marked last.
`include "lzss_decompressor_assert.svh"

module lzss_decompressor
  import lzss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [OFFSET_W-1:0] cfg_wr_data
);

  localparam int AW = OFFSET_W;
  localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EMIT  = 4'b1000
  } seq_state_t;

  seq_state_t          state;
  logic [OFFSET_W-1:0] init_pos;
  logic [OFFSET_W-1:0] restart_pos;
  logic [AW-1:0]       wp;
  logic [AW-1:0]       src;
  logic [4:0]          cnt;
  logic [7:0]          lit_byte;
  logic                is_lit;
  logic                last_pend;

  logic          in_fire;
  logic          emit_fire;
  logic          emit_done;
  logic [7:0]    rd_data;
  logic [7:0]    emit_byte;
  logic [AW-1:0] inc_in;
  logic [AW-1:0] inc_out;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  tok_dec_t      dec;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);
  assign emit_done = is_lit || (cnt == 5'd0);
  assign emit_byte = is_lit ? lit_byte : rd_data;

  // one incrementer serves the source address, write pointer and clear sweep
  assign inc_in  = (state == ST_READ) ? src : wp;
  assign inc_out = inc_in + AW'(1);

  // window write: clearing pass or decoded byte
  assign mem_we    = emit_fire || (state == ST_CLEAR);
  assign mem_wdata = (state == ST_CLEAR) ? 8'h00 : emit_byte;

  lzss_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (in_fire),
    .item   (in_data),
    .dec    (dec)
  );

  lzss_window #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_window (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp),
    .wdata (mem_wdata),
    .re    (state == ST_READ),
    .raddr (src),
    .rdata (rd_data)
  );

  // configuration register; start position is latched when a stream ends
  always_ff @(posedge clk) begin
    if (rst) begin
      init_pos    <= INIT_POS_RESET;
      restart_pos <= INIT_POS_RESET;
    end else begin
      if (cfg_wr_en) begin
        init_pos <= cfg_wr_data;
      end
      if (in_fire && in_data.last_in) begin
        restart_pos <= init_pos;
      end
    end
  end

  // sequencer and write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      wp    <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (wp == WP_LAST) begin
            wp    <= restart_pos;
            state <= ST_IDLE;
          end else begin
            wp <= inc_out;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            case (dec.kind)
              TOK_LIT:    state <= ST_EMIT;
              TOK_MATCH2: state <= ST_READ;
              default: begin
                // cut-short token at end of stream is dropped
                if (in_data.last_in) begin
                  wp    <= '0;
                  state <= ST_CLEAR;
                end
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            if (emit_done) begin
              if (last_pend) begin
                wp    <= '0;
                state <= ST_CLEAR;
              end else begin
                wp    <= inc_out;
                state <= ST_IDLE;
              end
            end else begin
              wp    <= inc_out;
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_CLEAR;
          wp    <= '0;
        end
      endcase
    end
  end

  // item context and copy counters
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lit_byte  <= in_data.in_byte;
      is_lit    <= (dec.kind == TOK_LIT);
      last_pend <= in_data.last_in;
      src       <= dec.offset[AW-1:0];
      cnt       <= {1'b0, dec.len_m3} + 5'd2;
    end else if (state == ST_READ) begin
      src <= inc_out;
    end else if (emit_fire && !emit_done) begin
      cnt <= cnt - 5'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.out_byte    <= emit_byte;
      out_data.last_of_run <= emit_done;
    end
  end

  // checks
  `LZSS_ASSERT_NEXT(a_lit_to_emit, clk, rst, in_fire && (dec.kind == TOK_LIT), state == ST_EMIT, "literal item did not go to emit")
  `LZSS_ASSERT_NEXT(a_read_to_emit, clk, rst, state == ST_READ, state == ST_EMIT, "window read not followed by emit")
  `LZSS_ASSERT_NEXT(a_clear_reload, clk, rst, (state == ST_CLEAR) && (wp == WP_LAST), wp == $past(restart_pos), "write pointer not reloaded after clear")

endmodule

// ===== src/lzss_window.sv =====
// 8-bit history window RAM: one write port, one registered read port.
// Depends on nothing.
module lzss_window #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lzss_parser.sv =====
// Token parser: flag bits, match phase and pending offset byte.
// Depends on lzss_pkg.
module lzss_parser
  import lzss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output tok_dec_t dec
);

  logic [7:0] flags;
  logic [3:0] flags_left;
  logic       phase;
  logic [7:0] off_lo;

  // classify the incoming byte
  always_comb begin
    dec.offset = {item.in_byte[7:4], off_lo};
    dec.len_m3 = item.in_byte[3:0];
    if (phase) begin
      dec.kind = TOK_MATCH2;
    end else if (flags_left == 4'd0) begin
      dec.kind = TOK_FLAG;
    end else if (flags[0]) begin
      dec.kind = TOK_LIT;
    end else begin
      dec.kind = TOK_MATCH1;
    end
  end

  // parser state; end of stream returns everything to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      flags_left <= '0;
      phase      <= 1'b0;
      off_lo     <= '0;
    end else if (accept) begin
      if (item.last_in) begin
        flags      <= '0;
        flags_left <= '0;
        phase      <= 1'b0;
        off_lo     <= '0;
      end else begin
        case (dec.kind)
          TOK_FLAG: begin
            flags      <= item.in_byte;
            flags_left <= 4'd8;
          end
          TOK_MATCH1: begin
            off_lo <= item.in_byte;
            phase  <= 1'b1;
          end
          TOK_LIT, TOK_MATCH2: begin
            flags      <= flags >> 1;
            flags_left <= flags_left - 4'd1;
            phase      <= 1'b0;
          end
          default: begin
            phase <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule
